/* src/rtpoa_pkg.sv */
package rtpoa_pkg;

    // Key codes of the telemetry records.
    localparam logic [7:0] KEY_DISTANCE = 8'h01;
    localparam logic [7:0] KEY_TIME     = 8'h02;
    localparam logic [7:0] KEY_AUX_03   = 8'h03;
    localparam logic [7:0] KEY_AUX_04   = 8'h04;
    localparam logic [7:0] KEY_AUX_05   = 8'h05;
    localparam logic [7:0] KEY_AUX_06   = 8'h06;
    localparam logic [7:0] KEY_SPEED    = 8'h21;
    localparam logic [7:0] KEY_AUX_22   = 8'h22;
    localparam logic [7:0] KEY_AUX_23   = 8'h23;
    localparam logic [7:0] KEY_ALTITUDE = 8'h24;
    localparam logic [7:0] KEY_AUX_25   = 8'h25;
    localparam logic [7:0] KEY_AUX_26   = 8'h26;
    localparam logic [7:0] KEY_AUX_A1   = 8'ha1;
    localparam logic [7:0] KEY_AUX_A2   = 8'ha2;

    localparam int LIMIT_W = 22;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HIGH_LIMIT = 2'd0;
    localparam logic [1:0] CFG_MID_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_LOW_LIMIT  = 2'd2;

    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RESET = 22'd120000;
    localparam logic [LIMIT_W-1:0] MID_LIMIT_RESET  = 22'd80000;
    localparam logic [LIMIT_W-1:0] LOW_LIMIT_RESET  = 22'd60000;

    // Speed is scaled by this factor before the limits are applied.
    localparam logic [5:0] SPEED_SCALE = 6'd36;

    typedef enum logic [2:0] {
        SLOT_NONE     = 3'd0,
        SLOT_DISTANCE = 3'd1,
        SLOT_TIME     = 3'd2,
        SLOT_SPEED    = 3'd3,
        SLOT_ALTITUDE = 3'd4
    } t_slot;

    // One commit request passed from the parser to the commit stage.
    typedef struct packed {
        logic [31:0] distance;
        logic [31:0] elapsed;
        logic [15:0] speed;
        logic [15:0] altitude;
        logic [3:0]  found;
        logic        stopped;
    } t_commit;

    typedef struct packed {
        logic [31:0] distance_m;
        logic [31:0] elapsed_s;
        logic [15:0] speed_raw;
        logic [15:0] altitude_raw;
        logic        distance_changed;
        logic        time_changed;
        logic        speed_changed;
        logic        altitude_changed;
        logic [1:0]  vibrate_pulses;
        logic        format_error;
    } t_result;

    // Queue status seen by the stage that feeds it and the stage that drains it.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Value length in bytes for a key; zero marks an unknown key.
    function automatic logic [2:0] key_size(input logic [7:0] key);
        logic [2:0] n;
        case (key)
            KEY_DISTANCE, KEY_TIME: n = 3'd4;
            KEY_AUX_03, KEY_AUX_04, KEY_AUX_05, KEY_AUX_06,
            KEY_SPEED, KEY_AUX_22, KEY_ALTITUDE: n = 3'd2;
            KEY_AUX_23, KEY_AUX_25, KEY_AUX_26, KEY_AUX_A1, KEY_AUX_A2: n = 3'd1;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic t_slot key_slot(input logic [7:0] key);
        t_slot s;
        case (key)
            KEY_DISTANCE: s = SLOT_DISTANCE;
            KEY_TIME:     s = SLOT_TIME;
            KEY_SPEED:    s = SLOT_SPEED;
            KEY_ALTITUDE: s = SLOT_ALTITUDE;
            default:      s = SLOT_NONE;
        endcase
        return s;
    endfunction

endpackage

/* src/rtpoa_front.sv */
module rtpoa_front
    import rtpoa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_is_last,
    output logic        o_cmd_push,
    output t_commit     o_cmd
);

    logic [2:0]  r_bytes_left, n_bytes_left;
    t_slot       r_slot, n_slot;
    logic [31:0] r_acc, n_acc;
    logic        r_stopped, n_stopped;
    logic [3:0]  r_found, n_found;
    logic [31:0] r_distance, n_distance;
    logic [31:0] r_elapsed, n_elapsed;
    logic [15:0] r_speed, n_speed;
    logic [15:0] r_altitude, n_altitude;
    logic [2:0]  size;

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_slot       = r_slot;
        n_acc        = r_acc;
        n_stopped    = r_stopped;
        n_found      = r_found;
        n_distance   = r_distance;
        n_elapsed    = r_elapsed;
        n_speed      = r_speed;
        n_altitude   = r_altitude;
        size         = key_size(i_msg_byte);

        if (i_take && !r_stopped) begin
            if (r_bytes_left == 3'd0) begin
                if (size == 3'd0) begin
                    n_stopped = 1'b1;
                end else begin
                    n_bytes_left = size;
                    n_slot       = key_slot(i_msg_byte);
                    n_acc        = '0;
                end
            end else begin
                n_acc        = {r_acc[23:0], i_msg_byte};
                n_bytes_left = r_bytes_left - 3'd1;
                if (n_bytes_left == 3'd0 && r_slot != SLOT_NONE) begin
                    // Only the first complete record of each tracked key counts.
                    case (r_slot)
                        SLOT_DISTANCE: begin
                            if (!r_found[0]) begin
                                n_found[0] = 1'b1;
                                n_distance = n_acc;
                            end
                        end
                        SLOT_TIME: begin
                            if (!r_found[1]) begin
                                n_found[1] = 1'b1;
                                n_elapsed  = n_acc;
                            end
                        end
                        SLOT_SPEED: begin
                            if (!r_found[2]) begin
                                n_found[2] = 1'b1;
                                n_speed    = n_acc[15:0];
                            end
                        end
                        SLOT_ALTITUDE: begin
                            if (!r_found[3]) begin
                                n_found[3] = 1'b1;
                                n_altitude = n_acc[15:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_slot = SLOT_NONE;
                end
            end
        end
    end

    assign o_cmd_push     = i_take && i_is_last;
    assign o_cmd.distance = n_distance;
    assign o_cmd.elapsed  = n_elapsed;
    assign o_cmd.speed    = n_speed;
    assign o_cmd.altitude = n_altitude;
    assign o_cmd.found    = n_found;
    assign o_cmd.stopped  = n_stopped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_slot       <= SLOT_NONE;
            r_acc        <= '0;
            r_stopped    <= 1'b0;
            r_found      <= '0;
        end else if (o_cmd_push) begin
            r_bytes_left <= '0;
            r_slot       <= SLOT_NONE;
            r_acc        <= '0;
            r_stopped    <= 1'b0;
            r_found      <= '0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_slot       <= n_slot;
            r_acc        <= n_acc;
            r_stopped    <= n_stopped;
            r_found      <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_distance <= n_distance;
        r_elapsed  <= n_elapsed;
        r_speed    <= n_speed;
        r_altitude <= n_altitude;
    end

endmodule

/* src/rtpoa_cmd_fifo.sv */
module rtpoa_cmd_fifo
    import rtpoa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_commit   i_data,
    input  logic      i_pop,
    output t_commit   o_data,
    output t_q_status o_status
);

    t_commit    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* src/rtpoa_back.sv */
module rtpoa_back
    import rtpoa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  t_commit            i_cmd,
    input  t_q_status          i_cmd_status,
    output logic               o_cmd_pop,
    input  logic               i_res_pop,
    output t_result            o_res,
    output logic               o_res_empty
);

    logic [LIMIT_W-1:0] r_high, r_mid, r_low;
    logic [31:0] r_shown_distance, n_shown_distance;
    logic [31:0] r_shown_elapsed, n_shown_elapsed;
    logic [15:0] r_shown_speed, n_shown_speed;
    logic [15:0] r_shown_altitude, n_shown_altitude;
    logic [1:0]  r_level, n_level;
    logic        r_fired, n_fired;
    logic [LIMIT_W-1:0] scaled;
    logic [1:0]  pulses;
    t_result     res;

    t_result     r_res_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        res_full;
    logic        res_pop;

    assign res_full    = (r_count == 2'd2);
    assign o_res_empty = (r_count == 2'd0);
    assign res_pop     = i_res_pop && !o_res_empty;
    assign o_cmd_pop   = !i_cmd_status.empty && !res_full;
    assign o_res       = r_res_mem[r_rd_ptr];

    always_comb begin
        n_shown_distance = i_cmd.found[0] ? i_cmd.distance : r_shown_distance;
        n_shown_elapsed  = i_cmd.found[1] ? i_cmd.elapsed  : r_shown_elapsed;
        n_shown_speed    = i_cmd.found[2] ? i_cmd.speed    : r_shown_speed;
        n_shown_altitude = i_cmd.found[3] ? i_cmd.altitude : r_shown_altitude;

        res.distance_m       = n_shown_distance;
        res.elapsed_s        = n_shown_elapsed;
        res.speed_raw        = n_shown_speed;
        res.altitude_raw     = n_shown_altitude;
        res.distance_changed = (n_shown_distance != r_shown_distance);
        res.time_changed     = (n_shown_elapsed != r_shown_elapsed);
        res.speed_changed    = (n_shown_speed != r_shown_speed);
        res.altitude_changed = (n_shown_altitude != r_shown_altitude)
                               && (n_shown_altitude != 16'd0);
        res.format_error     = i_cmd.stopped;

        // Three-level overspeed rule, only evaluated on a new speed.
        scaled  = LIMIT_W'(n_shown_speed) * LIMIT_W'(SPEED_SCALE);
        n_level = r_level;
        n_fired = r_fired;
        pulses  = 2'd0;
        if (res.speed_changed) begin
            if (scaled > r_high && (r_level == 2'd2 || !r_fired)) begin
                n_fired = 1'b0;
                n_level = 2'd3;
            end else if (scaled > r_mid && (r_level == 2'd1 || !r_fired)) begin
                n_fired = 1'b0;
                n_level = 2'd2;
            end else if (scaled > r_low && !r_fired) begin
                n_level = 2'd1;
            end else if (scaled <= r_low) begin
                n_fired = 1'b0;
                n_level = 2'd0;
            end
            if (n_level != 2'd0 && !n_fired) begin
                pulses  = n_level;
                n_fired = 1'b1;
            end
        end
        res.vibrate_pulses = pulses;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high <= HIGH_LIMIT_RESET;
            r_mid  <= MID_LIMIT_RESET;
            r_low  <= LOW_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HIGH_LIMIT: r_high <= i_cfg_data;
                CFG_MID_LIMIT:  r_mid  <= i_cfg_data;
                CFG_LOW_LIMIT:  r_low  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown_distance <= '0;
            r_shown_elapsed  <= '0;
            r_shown_speed    <= '0;
            r_shown_altitude <= '0;
            r_level          <= '0;
            r_fired          <= 1'b0;
        end else if (o_cmd_pop) begin
            r_shown_distance <= n_shown_distance;
            r_shown_elapsed  <= n_shown_elapsed;
            r_shown_speed    <= n_shown_speed;
            r_shown_altitude <= n_shown_altitude;
            r_level          <= n_level;
            r_fired          <= n_fired;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (o_cmd_pop) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (res_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (o_cmd_pop && !res_pop) begin
                r_count <= r_count + 2'd1;
            end else if (res_pop && !o_cmd_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_res_mem[r_wr_ptr] <= res;
        end
    end

endmodule

/* src/ride_telemetry_parser_overspeed_alert_core.sv */
// Ride telemetry parser with overspeed alert.
//
// Input side: a message arrives one byte per request on i_msg_byte, with
// i_is_last marking its final byte. A request is taken at a clock edge where
// push is high and full is low. Bytes that are not the last of a message
// never produce a result; the last byte of each message produces exactly one.
// Result side: while empty is low the oldest result sits on the o_ ports and
// is taken at an edge where pop is high.
// Throughput is one byte per cycle while full is low, messages back to back
// included. At the edge that takes the last byte of a message the parser
// hands its commit request to the commit queue; at a later edge, once the
// result queue has room, the commit stage updates the shown values, runs the
// overspeed rule and writes the result queue. If the receiver stalls, the
// two-entry result queue fills, the commit stage holds, the two-entry commit
// queue fills and then full is raised; bytes are never dropped. The user must
// write the limit registers through i_cfg_we, i_cfg_index and i_cfg_data
// only while the block is idle; the block itself does not enforce this.
// Synchronous reset clears the parse state, the shown values, the alert
// state and both queues, and loads the default speed limits.
module ride_telemetry_parser_overspeed_alert_core
    import rtpoa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_msg_byte,
    input  logic               i_is_last,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        o_distance_m,
    output logic [31:0]        o_elapsed_s,
    output logic [15:0]        o_speed_raw,
    output logic [15:0]        o_altitude_raw,
    output logic               o_distance_changed,
    output logic               o_time_changed,
    output logic               o_speed_changed,
    output logic               o_altitude_changed,
    output logic [1:0]         o_vibrate_pulses,
    output logic               o_format_error,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    logic      take;
    logic      cmd_push;
    t_commit   cmd_in;
    t_commit   cmd_head;
    t_q_status cmd_status;
    logic      cmd_pop;
    t_result   res;

    // The parser may only take a byte while the commit queue has room, since
    // any byte could turn out to be the last one of its message.
    assign full = cmd_status.full;
    assign take = push && !full;

    rtpoa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_msg_byte (i_msg_byte),
        .i_is_last  (i_is_last),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    rtpoa_cmd_fifo u_cmd_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (cmd_push),
        .i_data   (cmd_in),
        .i_pop    (cmd_pop),
        .o_data   (cmd_head),
        .o_status (cmd_status)
    );

    rtpoa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd_head),
        .i_cmd_status (cmd_status),
        .o_cmd_pop    (cmd_pop),
        .i_res_pop    (pop),
        .o_res        (res),
        .o_res_empty  (empty)
    );

    // Results leave the block as one port per field.
    assign o_distance_m       = res.distance_m;
    assign o_elapsed_s        = res.elapsed_s;
    assign o_speed_raw        = res.speed_raw;
    assign o_altitude_raw     = res.altitude_raw;
    assign o_distance_changed = res.distance_changed;
    assign o_time_changed     = res.time_changed;
    assign o_speed_changed    = res.speed_changed;
    assign o_altitude_changed = res.altitude_changed;
    assign o_vibrate_pulses   = res.vibrate_pulses;
    assign o_format_error     = res.format_error;

endmodule
